// File: rtl/core/gbte_pkg.sv
package gbte_pkg;

  localparam int CAPACITY = 1024;
  localparam int VIEW_LEN = 10;
  localparam int AW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);
  localparam int VW = $clog2(VIEW_LEN + 1);
  localparam int QDEPTH = 2;
  localparam int QW = $clog2(QDEPTH);

  localparam logic [1:0] MODE_INS = 2'd0;
  localparam logic [1:0] MODE_DEL = 2'd1;
  localparam logic [1:0] MODE_LEFT = 2'd2;
  localparam logic [1:0] MODE_RIGHT = 2'd3;

  localparam logic [1:0] KIND_INS = 2'd0;
  localparam logic [1:0] KIND_DEL = 2'd1;
  localparam logic [1:0] KIND_VIEW = 2'd2;
  localparam logic [1:0] KIND_EMPTY = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  ch;
    logic [10:0] count;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [10:0] value;
    logic        last;
  } res_t;

endpackage

// File: rtl/core/gbte_if.sv
interface gbte_in_if;
  logic              valid;
  logic              ready;
  gbte_pkg::cmd_t    data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface gbte_out_if;
  logic              valid;
  logic              ready;
  gbte_pkg::res_t    data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// File: rtl/core/gap_buffer_text_editor.sv
// Gap-buffer text editor with a cursor, kept as two character stacks.
// Insert and delete: result in the output register; next command after it is taken.
// Cursor move: a read and a write step per copied character, then a read and an
// output step per view character (up to 10): one registered read port per stack.
// Reset (rst_n low, synchronous) empties both stacks and the command queue; stack
// memories are not cleared, since only written entries are ever read.
module gap_buffer_text_editor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_ch,
  input  logic [10:0] in_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [10:0] out_value,
  output logic        out_last
);

  gbte_in_if  in_ch_if ();
  gbte_in_if  q_if ();
  gbte_out_if out_if ();

  // Input transfer side.
  assign in_ch_if.valid = in_valid;
  assign in_ch_if.data = '{mode: in_mode, ch: in_ch, count: in_count};
  assign in_ready = in_ch_if.ready;

  // The front queues commands so the host can keep issuing while the back
  // is busy copying characters across the cursor.
  gbte_front u_front (.clk(clk), .rst_n(rst_n), .in_ch(in_ch_if.sink), .q_ch(q_if.source));

  // The back owns both stacks and the output register.
  gbte_back u_back (.clk(clk), .rst_n(rst_n), .q_ch(q_if.sink), .out_ch(out_if.source));

  assign out_valid = out_if.valid;
  assign out_if.ready = out_ready;
  assign out_kind = out_if.data.kind;
  assign out_value = out_if.data.value;
  assign out_last = out_if.data.last;

  // A result waiting for transfer must not change.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_kind))
    else $error("result changed while stalled");

  // Status and count results always end their item.
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == gbte_pkg::KIND_INS || out_kind == gbte_pkg::KIND_DEL ||
                  out_kind == gbte_pkg::KIND_EMPTY) |-> out_last)
    else $error("single result without last");

  // Insert status is a single bit.
  a_ins_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == gbte_pkg::KIND_INS |-> out_value[10:1] == 10'd0)
    else $error("bad insert status");

endmodule

// File: rtl/core/gbte_front.sv
module gbte_front (
  input  logic          clk,
  input  logic          rst_n,
  gbte_in_if.sink       in_ch,
  gbte_in_if.source     q_ch
);

  // Two-entry queue of accepted commands; counts are saturated here.
  gbte_pkg::cmd_t mem_r [gbte_pkg::QDEPTH];
  logic [gbte_pkg::QW-1:0] wp_r, rp_r;
  logic [gbte_pkg::QW:0] cnt_r;
  logic push, pop;
  gbte_pkg::cmd_t c;

  assign in_ch.ready = (cnt_r < (gbte_pkg::QW+1)'(gbte_pkg::QDEPTH));
  assign push = in_ch.valid && in_ch.ready;
  assign pop = q_ch.valid && q_ch.ready;
  assign q_ch.valid = cnt_r != '0;
  assign q_ch.data = mem_r[rp_r];

  always_comb begin
    c = in_ch.data;
    if (c.count > 11'(gbte_pkg::CAPACITY)) c.count = 11'(gbte_pkg::CAPACITY);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        mem_r[wp_r] <= c;
        wp_r <= wp_r + 1'b1;
      end
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (gbte_pkg::QW+1)'(push) - (gbte_pkg::QW+1)'(pop);
    end
  end

endmodule

// File: rtl/core/gbte_back.sv
module gbte_back (
  input  logic          clk,
  input  logic          rst_n,
  gbte_in_if.sink       q_ch,
  gbte_out_if.source    out_ch
);

  typedef enum logic [2:0] {
    S_IDLE, S_MOVE_RD, S_MOVE_WR, S_VIEW_RD, S_VIEW_OUT, S_OUT
  } state_t;

  localparam int AW = gbte_pkg::AW;
  localparam int LW = gbte_pkg::LW;

  state_t state_r;
  logic [LW-1:0] blen_r, alen_r, n_r;
  logic [LW-1:0] vpos_r, vend_r;
  logic dir_left_r;
  gbte_pkg::res_t res_r;
  logic valid_r;

  logic [7:0] bmem [gbte_pkg::CAPACITY];
  logic [7:0] amem [gbte_pkg::CAPACITY];
  logic [7:0] brd_r, ard_r;
  logic [AW-1:0] brd_a, ard_a;
  logic bwe, awe;
  logic [AW-1:0] bwa, awa;
  logic [7:0] bwd, awd;

  gbte_pkg::cmd_t cmd;
  logic [LW-1:0] navail, nmove, vn;

  assign cmd = q_ch.data;
  assign q_ch.ready = (state_r == S_IDLE) && !valid_r;
  assign out_ch.valid = valid_r;
  assign out_ch.data = res_r;

  always_comb begin
    navail = (cmd.mode == gbte_pkg::MODE_LEFT) ? blen_r : alen_r;
    nmove = (cmd.count < navail) ? cmd.count : navail;
    vn = (blen_r < LW'(gbte_pkg::VIEW_LEN)) ? blen_r : LW'(gbte_pkg::VIEW_LEN);
  end

  // Memory ports: reads registered, one write per cycle per stack.
  always_comb begin
    brd_a = dir_left_r ? AW'(blen_r - 1'b1) : AW'(vpos_r);
    ard_a = AW'(alen_r - 1'b1);
    bwe = 1'b0; bwa = AW'(blen_r); bwd = ard_r;
    awe = 1'b0; awa = AW'(alen_r); awd = brd_r;
    if (state_r == S_IDLE && q_ch.valid && q_ch.ready && cmd.mode == gbte_pkg::MODE_INS &&
        (blen_r + alen_r) < LW'(gbte_pkg::CAPACITY)) begin
      bwe = 1'b1; bwd = cmd.ch;
    end
    if (state_r == S_MOVE_WR) begin
      if (dir_left_r) awe = 1'b1;
      else bwe = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (bwe) bmem[bwa] <= bwd;
    if (awe) amem[awa] <= awd;
    brd_r <= bmem[brd_a];
    ard_r <= amem[ard_a];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      blen_r <= '0;
      alen_r <= '0;
      valid_r <= 1'b0;
      n_r <= '0;
      vpos_r <= '0;
      vend_r <= '0;
      dir_left_r <= 1'b0;
    end else begin
      if (valid_r && out_ch.ready) valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_ch.valid && q_ch.ready) begin
            case (cmd.mode)
              gbte_pkg::MODE_INS: begin
                res_r.kind <= gbte_pkg::KIND_INS;
                res_r.last <= 1'b1;
                if ((blen_r + alen_r) < LW'(gbte_pkg::CAPACITY)) begin
                  blen_r <= blen_r + 1'b1;
                  res_r.value <= 11'd1;
                end else res_r.value <= 11'd0;
                valid_r <= 1'b1;
              end
              gbte_pkg::MODE_DEL: begin
                res_r.kind <= gbte_pkg::KIND_DEL;
                res_r.last <= 1'b1;
                res_r.value <= 11'((cmd.count < blen_r) ? cmd.count : blen_r);
                blen_r <= blen_r - ((cmd.count < blen_r) ? cmd.count : blen_r);
                valid_r <= 1'b1;
              end
              default: begin
                dir_left_r <= (cmd.mode == gbte_pkg::MODE_LEFT);
                n_r <= nmove;
                state_r <= S_MOVE_RD;
              end
            endcase
          end
        end
        S_MOVE_RD: begin
          if (n_r == '0) begin
            dir_left_r <= 1'b0;
            vpos_r <= blen_r - vn;
            vend_r <= blen_r;
            if (vn == '0) begin
              res_r.kind <= gbte_pkg::KIND_EMPTY;
              res_r.value <= 11'd0;
              res_r.last <= 1'b1;
              valid_r <= 1'b1;
              state_r <= S_IDLE;
            end else state_r <= S_VIEW_RD;
          end else state_r <= S_MOVE_WR;
        end
        S_MOVE_WR: begin
          if (dir_left_r) begin
            blen_r <= blen_r - 1'b1;
            alen_r <= alen_r + 1'b1;
          end else begin
            alen_r <= alen_r - 1'b1;
            blen_r <= blen_r + 1'b1;
          end
          n_r <= n_r - 1'b1;
          state_r <= S_MOVE_RD;
        end
        S_VIEW_RD: begin
          if (!valid_r || out_ch.ready) begin
            state_r <= S_VIEW_OUT;
          end
        end
        S_VIEW_OUT: begin
          res_r.kind <= gbte_pkg::KIND_VIEW;
          res_r.value <= {3'd0, brd_r};
          res_r.last <= (vpos_r + 1'b1 == vend_r);
          valid_r <= 1'b1;
          vpos_r <= vpos_r + 1'b1;
          state_r <= (vpos_r + 1'b1 == vend_r) ? S_IDLE : S_VIEW_RD;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the gap-buffer text editor.
//
// A behavioral copy of the two character stacks runs beside the block. Every
// command transfer on the input channel is fed to it, and the results it
// predicts wait in a queue. Every result transfer on the output channel is
// compared field by field with the oldest waiting prediction.
module testbench;

  localparam int AW = gbte_pkg::AW;

  logic clk;
  logic rst_n;

  gbte_in_if  cmd_ch ();
  gbte_out_if res_ch ();

  gap_buffer_text_editor i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cmd_ch.valid),
    .in_ready  (cmd_ch.ready),
    .in_mode   (cmd_ch.data.mode),
    .in_ch     (cmd_ch.data.ch),
    .in_count  (cmd_ch.data.count),
    .out_valid (res_ch.valid),
    .out_ready (res_ch.ready),
    .out_kind  (res_ch.data.kind),
    .out_value (res_ch.data.value),
    .out_last  (res_ch.data.last)
  );

  localparam int WATCHDOG_LIMIT = 20000;

  // Shadow copy of the text: the stacks before and after the cursor.
  logic [7:0] text_left [gbte_pkg::CAPACITY];
  logic [7:0] text_right[gbte_pkg::CAPACITY];
  int         left_len;
  int         right_len;

  gbte_pkg::res_t pending_results[$];
  int         mismatch_count;
  int         sender_idle_pct;
  int         receiver_idle_pct;
  int         receiver_hold_cycles;
  int         quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Adds one prediction at the tail of the queue.
  function automatic void queue_result(gbte_pkg::res_t r);
    pending_results = {pending_results, r};
  endfunction

  // Appends the view of the last characters before the cursor, oldest first.
  function automatic void push_cursor_view();
    int n;
    gbte_pkg::res_t r;
    n = (left_len < gbte_pkg::VIEW_LEN) ? left_len : gbte_pkg::VIEW_LEN;
    if (n == 0) begin
      r.kind  = gbte_pkg::KIND_EMPTY;
      r.value = '0;
      r.last  = 1'b1;
      queue_result(r);
    end else begin
      for (int i = 0; i < n; i++) begin
        r.kind  = gbte_pkg::KIND_VIEW;
        r.value = {3'b000, text_left[AW'(left_len - n + i)]};
        r.last  = (i == n - 1);
        queue_result(r);
      end
    end
  endfunction

  // Applies one command to the shadow text and queues the results it causes.
  function automatic void apply_edit(gbte_pkg::cmd_t c);
    int n;
    gbte_pkg::res_t r;
    r.last = 1'b1;
    case (c.mode)
      gbte_pkg::MODE_INS: begin
        r.kind = gbte_pkg::KIND_INS;
        if (left_len + right_len >= gbte_pkg::CAPACITY) begin
          r.value = '0;
        end else begin
          text_left[AW'(left_len)] = c.ch;
          left_len++;
          r.value = 11'd1;
        end
        queue_result(r);
      end
      gbte_pkg::MODE_DEL: begin
        n = (c.count < left_len) ? c.count : left_len;
        left_len -= n;
        r.kind  = gbte_pkg::KIND_DEL;
        r.value = 11'(n);
        queue_result(r);
      end
      gbte_pkg::MODE_LEFT: begin
        n = (c.count < left_len) ? c.count : left_len;
        repeat (n) begin
          left_len--;
          text_right[AW'(right_len)] = text_left[AW'(left_len)];
          right_len++;
        end
        push_cursor_view();
      end
      default: begin
        n = (c.count < right_len) ? c.count : right_len;
        repeat (n) begin
          right_len--;
          text_left[AW'(left_len)] = text_right[AW'(right_len)];
          left_len++;
        end
        push_cursor_view();
      end
    endcase
  endfunction

  // Offers one command, with a random idle gap first, and waits for its transfer.
  // Valid stays high after a transfer so back-to-back commands need no toggle.
  task automatic send_edit(logic [1:0] mode, logic [7:0] ch, logic [10:0] count);
    gbte_pkg::cmd_t c;
    c.mode  = mode;
    c.ch    = ch;
    c.count = count;
    if ($urandom_range(99) < sender_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.data  <= c;
    do @(posedge clk); while (!cmd_ch.ready);
    apply_edit(c);
  endtask

  // Output side: random stalls, or a long counted hold-off when requested.
  always @(posedge clk) begin
    if (receiver_hold_cycles > 0) begin
      res_ch.ready <= 1'b0;
      receiver_hold_cycles <= receiver_hold_cycles - 1;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // Result checker: each result transfer against the oldest prediction.
  always @(posedge clk) begin
    gbte_pkg::res_t exp_r;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Unexpected result: kind %0d value %0d last %0d",
                   res_ch.data.kind, res_ch.data.value, res_ch.data.last);
      end else begin
        exp_r = pending_results[0];
        pending_results.delete(0);
        if (res_ch.data !== exp_r) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Mismatch: expected kind %0d value %0d last %0d, got %0d %0d %0d",
                     exp_r.kind, exp_r.value, exp_r.last,
                     res_ch.data.kind, res_ch.data.value, res_ch.data.last);
        end
      end
    end
  end

  // Watchdog on cycles in which no transfer happens on either channel.
  always @(posedge clk) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d results outstanding", pending_results.size());
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Basic editing: inserts of both extreme bytes, deletes, short moves.
  task automatic test_basic_edits();
    send_edit(gbte_pkg::MODE_LEFT, 8'h00, 11'd3);
    send_edit(gbte_pkg::MODE_DEL, 8'h00, 11'd1);
    send_edit(gbte_pkg::MODE_INS, 8'h00, 11'd0);
    send_edit(gbte_pkg::MODE_INS, 8'hFF, 11'h7FF);
    for (int i = 0; i < 12; i++)
      send_edit(gbte_pkg::MODE_INS, 8'(8'h41 + i), 11'd0);
    send_edit(gbte_pkg::MODE_LEFT, 8'h00, 11'd4);
    send_edit(gbte_pkg::MODE_INS, 8'h5A, 11'd0);
    send_edit(gbte_pkg::MODE_RIGHT, 8'h00, 11'd2);
    send_edit(gbte_pkg::MODE_DEL, 8'hFF, 11'd3);
  endtask

  // Count edge values: zero, saturation, and the largest encodable count.
  task automatic test_count_extremes();
    send_edit(gbte_pkg::MODE_DEL, 8'h00, 11'd0);
    send_edit(gbte_pkg::MODE_LEFT, 8'h00, 11'd0);
    send_edit(gbte_pkg::MODE_RIGHT, 8'h00, 11'd0);
    send_edit(gbte_pkg::MODE_RIGHT, 8'h00, 11'h7FF);
    send_edit(gbte_pkg::MODE_LEFT, 8'h00, 11'd1024);
    send_edit(gbte_pkg::MODE_RIGHT, 8'h00, 11'd1025);
    send_edit(gbte_pkg::MODE_DEL, 8'h00, 11'h7FF);
    send_edit(gbte_pkg::MODE_DEL, 8'h00, 11'd5);
  endtask

  // Random edits: mostly typing with small moves and deletes, some wide counts.
  task automatic test_random_edits(int n_items);
    int sel;
    logic [10:0] cnt;
    repeat (n_items) begin
      sel = $urandom_range(99);
      cnt = 11'(($urandom_range(9) == 0) ? $urandom_range(2047) : $urandom_range(12));
      if (sel < 50)
        send_edit(gbte_pkg::MODE_INS, 8'($urandom_range(255)), 11'($urandom_range(2047)));
      else if (sel < 64)
        send_edit(gbte_pkg::MODE_DEL, 8'($urandom_range(255)), cnt);
      else if (sel < 82)
        send_edit(gbte_pkg::MODE_LEFT, 8'($urandom_range(255)), cnt);
      else
        send_edit(gbte_pkg::MODE_RIGHT, 8'($urandom_range(255)), cnt);
    end
  endtask

  // The receiver holds off for a long stretch while commands keep coming, so the
  // block fills up and must stall its input.
  task automatic test_output_backpressure();
    receiver_hold_cycles = 300;
    for (int i = 0; i < 20; i++)
      send_edit(gbte_pkg::MODE_INS, 8'(8'h61 + i), 11'd0);
    send_edit(gbte_pkg::MODE_LEFT, 8'h00, 11'd5);
    send_edit(gbte_pkg::MODE_RIGHT, 8'h00, 11'd2);
  endtask

  initial begin
    rst_n                = 1'b0;
    cmd_ch.valid         = 1'b0;
    cmd_ch.data          = '0;
    res_ch.ready         = 1'b0;
    left_len             = 0;
    right_len            = 0;
    mismatch_count       = 0;
    sender_idle_pct      = 0;
    receiver_idle_pct    = 0;
    receiver_hold_cycles = 0;
    quiet_cycles         = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_edits();
    test_count_extremes();

    // Random traffic under three idling profiles.
    sender_idle_pct   = 32;
    receiver_idle_pct = 80;
    test_random_edits(85);
    sender_idle_pct   = 80;
    receiver_idle_pct = 32;
    test_random_edits(85);
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    test_random_edits(85);

    test_output_backpressure();

    cmd_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: gap_buffer_text_editor.f
rtl/core/gbte_pkg.sv
rtl/core/gbte_if.sv
rtl/core/gbte_front.sv
rtl/core/gbte_back.sv
rtl/core/gap_buffer_text_editor.sv
test/testbench.sv
